[sv/ftfc_pkg.sv]
`default_nettype none
package ftfc_pkg;

  localparam int unsigned Co2W      = 16;
  localparam int unsigned HumW      = 14;
  localparam int unsigned ThrPctW   = 7;
  localparam int unsigned OvrMinW   = 11;
  localparam int unsigned ElapsedW  = 17;
  localparam int unsigned ErrRunW   = 8;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 40;

  localparam int unsigned HumScale  = 100;
  localparam int unsigned SecsPerMin = 60;

  // x/5 for x < 2**19: multiply by ceil(2**21/5), keep bits 21 and up
  localparam int unsigned SumW      = Co2W + 3;
  localparam int unsigned Div5Shift = 21;
  localparam logic [SumW-1:0] Div5Mul = SumW'(419431);

  localparam logic [3:0] ErrLimitRst = 4'd3;

  // item kinds (tuser)
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_MODE   = 2'd2;

  // fan modes
  localparam logic [1:0] MODE_AUTO    = 2'd0;
  localparam logic [1:0] MODE_MAN_OFF = 2'd1;
  localparam logic [1:0] MODE_MAN_ON  = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_CO2_THR   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HUM_THR   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_OVR_MIN   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_ERR_LIMIT = 2'd3;

  typedef struct packed {
    logic [Co2W-1:0]     co2_thr;
    logic [HumW-1:0]     hum_thr_centi;
    logic [ElapsedW-1:0] ovr_secs;
    logic [ErrRunW-1:0]  err_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      new_mode;
    logic            sensor_error;
    logic [HumW-1:0] humidity_centi;
    logic [Co2W-1:0] co2_ppm;
  } item_t;

  typedef struct packed {
    logic [Co2W-1:0]     last_co2;
    logic [HumW-1:0]     last_hum;
    logic [Co2W-1:0]     avg_co2;
    logic [HumW-1:0]     avg_hum;
    logic                avg_loaded;
    logic                fan_state;
    logic [1:0]          fan_mode;
    logic [ElapsedW-1:0] elapsed;
    logic [ErrRunW-1:0]  error_run;
  } state_t;

  typedef struct packed {
    logic            mode_error;
    logic            hw_fail;
    logic [HumW-1:0] filtered_humidity;
    logic [Co2W-1:0] filtered_co2;
    logic [1:0]      mode_now;
    logic [1:0]      fan_status;
    logic            fan_on;
  } result_t;

  // (20*last + 80*avg) / 100 == (last + 4*avg) / 5
  function automatic logic [Co2W-1:0] filt(input logic [Co2W-1:0] last,
                                           input logic [Co2W-1:0] avg);
    logic [SumW-1:0]   sum;
    logic [2*SumW-1:0] prod;
    sum  = SumW'(last) + {1'b0, avg, 2'b00};
    prod = (2*SumW)'(sum) * (2*SumW)'(Div5Mul);
    return prod[Div5Shift +: Co2W];
  endfunction

endpackage
`default_nettype wire

[sv/ftfc_core.sv]
`default_nettype none
module ftfc_core (
  input  ftfc_pkg::cfg_t    cfg_i,
  input  ftfc_pkg::state_t  state_i,
  input  logic [1:0]        func_i,
  input  ftfc_pkg::item_t   item_i,
  output ftfc_pkg::state_t  state_o,
  output ftfc_pkg::result_t result_o
);
  import ftfc_pkg::*;

  state_t st;
  logic   mode_err;
  logic   do_exp;
  logic   do_dec;

  always_comb begin
    st       = state_i;
    mode_err = 1'b0;
    do_exp   = 1'b0;
    do_dec   = 1'b0;
    case (func_i)
      FUNC_SAMPLE: begin
        if (item_i.sensor_error) begin
          if (st.error_run != '1) begin
            st.error_run = st.error_run + 1'b1;
          end
        end else if (item_i.co2_ppm != '0) begin
          st.error_run = '0;
          st.last_co2  = item_i.co2_ppm;
          st.last_hum  = item_i.humidity_centi;
        end
        if (st.avg_loaded) begin
          st.avg_co2 = filt(st.last_co2, st.avg_co2);
          st.avg_hum = HumW'(filt(Co2W'(st.last_hum), Co2W'(st.avg_hum)));
        end else begin
          st.avg_co2    = st.last_co2;
          st.avg_hum    = st.last_hum;
          st.avg_loaded = 1'b1;
        end
        do_exp = 1'b1;
        do_dec = 1'b1;
      end
      FUNC_TICK: begin
        if (st.fan_mode == MODE_MAN_ON && st.elapsed != '1) begin
          st.elapsed = st.elapsed + 1'b1;
        end
      end
      FUNC_MODE: begin
        if (item_i.new_mode == MODE_INVALID) begin
          mode_err = 1'b1;
        end else if (item_i.new_mode == st.fan_mode) begin
          do_exp = 1'b1;
          do_dec = 1'b1;
        end else begin
          st.elapsed  = '0;
          st.fan_mode = item_i.new_mode;
          do_dec      = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_exp && st.fan_mode == MODE_MAN_ON && st.elapsed > cfg_i.ovr_secs) begin
      st.fan_mode = MODE_AUTO;
      st.elapsed  = '0;
    end

    if (do_dec) begin
      case (st.fan_mode)
        MODE_MAN_OFF: st.fan_state = 1'b0;
        MODE_MAN_ON:  st.fan_state = 1'b1;
        default:      st.fan_state = (st.avg_hum > cfg_i.hum_thr_centi) ||
                                     (st.avg_co2 > cfg_i.co2_thr);
      endcase
    end
  end

  assign state_o = st;

  always_comb begin
    result_o.fan_on            = st.fan_state;
    result_o.fan_status        = {st.fan_mode != MODE_AUTO, st.fan_state};
    result_o.mode_now          = st.fan_mode;
    result_o.filtered_co2      = st.avg_co2;
    result_o.filtered_humidity = st.avg_hum;
    result_o.hw_fail           = st.error_run > cfg_i.err_limit;
    result_o.mode_error        = mode_err;
  end

endmodule
`default_nettype wire

[sv/filtered_threshold_fan_controller.sv]
// Throughput: one item per cycle while m_axis_tready holds; the state update
// is a single pass through the core between the input and result registers.
// Both sides are decoupled by the result register, so a stall downstream
// blocks input only once the input register is also full.
// Reset clears state_q and the valid flags, but not the item and result data;
// error_limit resets to 3, the other config registers to 0.
`default_nettype none
module filtered_threshold_fan_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // co2_ppm[15:0], humidity_centi[29:16], sensor_error[30], new_mode[32:31]
  input  logic [ftfc_pkg::InDataW-1:0]       s_axis_tdata,
  // func[1:0]
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // fan_on[0], fan_status[2:1], mode_now[4:3], filtered_co2[20:5],
  // filtered_humidity[34:21], hw_fail[35], mode_error[36]
  output logic [ftfc_pkg::OutDataW-1:0]      m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [ftfc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [ftfc_pkg::CfgDataW-1:0]      cfg_data_i
);
  import ftfc_pkg::*;

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  logic    in_v_q;
  logic [1:0] in_func_q;
  item_t   in_item_q;
  logic    out_v_q;
  result_t out_res_q;
  result_t res_d;
  logic    advance;
  logic    s_accept;

  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.co2_thr       <= '0;
      cfg_q.hum_thr_centi <= '0;
      cfg_q.ovr_secs      <= '0;
      cfg_q.err_limit     <= ErrRunW'(ErrLimitRst);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CO2_THR:   cfg_q.co2_thr <= cfg_data_i[Co2W-1:0];
        REG_HUM_THR:   cfg_q.hum_thr_centi <=
                         HumW'(cfg_data_i[ThrPctW-1:0]) * HumW'(HumScale);
        REG_OVR_MIN:   cfg_q.ovr_secs <=
                         ElapsedW'(cfg_data_i[OvrMinW-1:0]) * ElapsedW'(SecsPerMin);
        REG_ERR_LIMIT: cfg_q.err_limit <= cfg_data_i[ErrRunW-1:0];
        default: begin
        end
      endcase
    end
  end

  ftfc_core u_core (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .func_i   (in_func_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q <= s_accept || (in_v_q && !advance);
      if (advance) begin
        state_q <= state_d;
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_func_q                <= s_axis_tuser;
      in_item_q.co2_ppm        <= s_axis_tdata[Co2W-1:0];
      in_item_q.humidity_centi <= s_axis_tdata[Co2W +: HumW];
      in_item_q.sensor_error   <= s_axis_tdata[Co2W+HumW];
      in_item_q.new_mode       <= s_axis_tdata[Co2W+HumW+1 +: 2];
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OutDataW'(out_res_q);

endmodule
`default_nettype wire
